>>> sv/power_throttle_threshold_monitor_defines.svh
// Assertion helpers for the monitor's top-level RTL file.
`ifndef POWER_THROTTLE_THRESHOLD_MONITOR_DEFINES_SVH
`define POWER_THROTTLE_THRESHOLD_MONITOR_DEFINES_SVH

// Same-cycle implication, sampled on clock, masked during reset.
`define PTM_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, masked during reset.
`define PTM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ptm_pkg.sv
`default_nettype none

package ptm_pkg;

   localparam int VALUE_W = 17;
   localparam int CNT_W   = 6;
   localparam int MA_W    = 14;
   localparam int MV_W    = 12;
   localparam int LIMIT_W = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;

   localparam logic [1:0] FUNC_TICK     = 2'd0;
   localparam logic [1:0] FUNC_IDENTIFY = 2'd1;
   localparam logic [1:0] FUNC_REMOVE   = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BATT_HIGH_SLOW    = 3'd0,
      CSR_BATT_HIGH_FAST    = 3'd1,
      CSR_BATT_LOW          = 3'd2,
      CSR_SLOW_ASSERT_COUNT = 3'd3,
      CSR_RELEASE_COUNT     = 3'd4,
      CSR_ID_65W_LOW        = 3'd5,
      CSR_ID_65W_HIGH       = 3'd6
   } csr_index_type;

   // adapter kind 0 = 45W, 1 = 65W; slots past the fast one repeat it
   localparam logic [MV_W-1:0] AD_HI [2][4] = '{
      '{12'd2308, 12'd2359, 12'd2359, 12'd2359},
      '{12'd3333, 12'd3385, 12'd3385, 12'd3385}
   };
   localparam logic [MV_W-1:0] AD_LO [2] = '{12'd1385, 12'd2000};
   localparam logic [LIMIT_W-1:0] AD_LIMIT [2] = '{12'h800, 12'hc00};

   typedef struct packed {
      logic set;
      logic clr;
   } det_event_type;

   typedef struct packed {
      logic [1:0]             func;
      logic signed [15:0]     battery_current;
      logic [MA_W-1:0]        adapter_current;
      logic                   ap_off;
      logic [MV_W-1:0]        id_millivolts;
   } req_item_type;

endpackage

`default_nettype wire

>>> sv/ptm_if.sv
`default_nettype none

interface ptm_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     func;
   logic signed [15:0]             battery_current;
   logic [ptm_pkg::MA_W-1:0]       adapter_current;
   logic                           ap_off;
   logic [ptm_pkg::MV_W-1:0]       id_millivolts;

   modport source (output valid, func, battery_current, adapter_current, ap_off,
                   id_millivolts, input ready);
   modport sink (input valid, func, battery_current, adapter_current, ap_off,
                 id_millivolts, output ready);
endinterface

interface ptm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           throttle;
   logic [3:0]                     throttle_reasons;
   logic                           adapter_class;
   logic [ptm_pkg::LIMIT_W-1:0]    input_current_limit;

   modport source (output valid, throttle, throttle_reasons, adapter_class,
                   input_current_limit, input ready);
   modport sink (input valid, throttle, throttle_reasons, adapter_class,
                 input_current_limit, output ready);
endinterface

interface ptm_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ptm_pkg::CSR_INDEX_W-1:0]   index;
   logic [ptm_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/ptm_detector.sv
`default_nettype none

module ptm_detector (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               en,
   input  wire logic signed [ptm_pkg::VALUE_W-1:0] value,
   input  wire logic signed [ptm_pkg::VALUE_W-1:0] hi,
   input  wire logic signed [ptm_pkg::VALUE_W-1:0] lo,
   input  wire logic [ptm_pkg::CNT_W-1:0]          hi_cnt,
   input  wire logic [ptm_pkg::CNT_W-1:0]          lo_cnt,
   output ptm_pkg::det_event_type                  ev
);

   logic [ptm_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      trig_ff, trig_in;
   logic [ptm_pkg::CNT_W:0]   bump;

   always_comb begin
      count_in = count_ff;
      trig_in  = trig_ff;
      ev       = '0;
      bump     = {1'b0, count_ff} + (ptm_pkg::CNT_W+1)'(1);
      if (en) begin
         if (trig_ff) begin
            if (value < lo) begin
               if (bump >= {1'b0, lo_cnt}) begin
                  ev.clr   = 1'b1;
                  count_in = '0;
                  trig_in  = 1'b0;
               end else begin
                  count_in = bump[ptm_pkg::CNT_W-1:0];
               end
            end else begin
               count_in = '0;
            end
         end else begin
            if (value > hi) begin
               if (bump >= {1'b0, hi_cnt}) begin
                  ev.set   = 1'b1;
                  count_in = '0;
                  trig_in  = 1'b1;
               end else begin
                  count_in = bump[ptm_pkg::CNT_W-1:0];
               end
            end else begin
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         trig_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         trig_ff  <= trig_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/power_throttle_threshold_monitor.sv
// Power throttle threshold monitor.
// Requests arrive on req_chan (valid/ready): a tick with battery and adapter
// current, an adapter-identified event with the ID voltage, or an
// adapter-removed event. Every request yields exactly one response on
// rsp_chan: throttle, the reason bits, the adapter type and its input
// current limit, all as they stand after that request.
// Thresholds and counts are written on csr_chan, which is always ready;
// write it only while no request is in flight.
// An accepted request has its response registered once the output register
// is free. Throughput is one request per cycle while rsp_chan does not stall:
// the detectors update in the cycle a request leaves the input register, so
// the next request sees the new state straight away. If rsp_chan stalls, the
// response holds, one more request is taken into the input register and then
// req_chan.ready falls until the response is taken.
// Reset (synchronous) clears every debounce count, triggered flag and reason
// bit, selects the 45W adapter and loads the default thresholds.
`default_nettype none
`include "power_throttle_threshold_monitor_defines.svh"

module power_throttle_threshold_monitor #(
   parameter int BATT_DETECTORS    = 2,
   parameter int ADAPTER_DETECTORS = 2,
   parameter int ADAPTER_KINDS     = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ptm_req_if.sink    req_chan,
   ptm_rsp_if.source  rsp_chan,
   ptm_csr_if.sink    csr_chan
);

   localparam int NUM_DET  = BATT_DETECTORS + ADAPTER_DETECTORS * ADAPTER_KINDS;
   localparam int REASON_W = BATT_DETECTORS + ADAPTER_DETECTORS;

   function automatic int slot_bit(input int s);
      if (s < BATT_DETECTORS) return s;
      return BATT_DETECTORS + (s - BATT_DETECTORS) % ADAPTER_DETECTORS;
   endfunction

   // configuration
   logic [ptm_pkg::MA_W-1:0]  batt_high_slow_ff, batt_high_fast_ff, batt_low_ff;
   logic [ptm_pkg::CNT_W-1:0] slow_cnt_ff, release_cnt_ff;
   logic [ptm_pkg::MV_W-1:0]  id_low_ff, id_high_ff;

   // input register
   logic                  item_valid_ff;
   ptm_pkg::req_item_type item_ff;

   // block state
   logic [REASON_W-1:0]   reason_ff, reason_in;
   logic                  adapter_ff, adapter_in;

   // response register
   logic                         rsp_valid_ff;
   logic                         rsp_throttle_ff;
   logic [3:0]                   rsp_reasons_ff;
   logic                         rsp_adapter_ff;
   logic [ptm_pkg::LIMIT_W-1:0]  rsp_limit_ff;

   logic adv, is_tick;
   logic signed [ptm_pkg::VALUE_W-1:0] discharge, ad_value;
   logic [REASON_W-1:0]   set_bits, clr_bits;
   logic [REASON_W+3:0]   reason_ext;
   ptm_pkg::det_event_type det_ev [NUM_DET];

   assign adv     = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign is_tick = (item_ff.func == ptm_pkg::FUNC_TICK);
   assign req_chan.ready = !item_valid_ff || adv;
   assign csr_chan.ready = 1'b1;

   assign discharge = ptm_pkg::VALUE_W'(0)
                    - {item_ff.battery_current[15], item_ff.battery_current};
   assign ad_value  = $signed({3'b000, item_ff.adapter_current});

   for (genvar s = 0; s < NUM_DET; s++) begin : g_slot
      if (s < BATT_DETECTORS) begin : g_batt
         ptm_detector u_det (
            .clock  (clock),
            .reset  (reset),
            .en     (adv && is_tick),
            .value  (discharge),
            .hi     ($signed({3'b000, (s == 0) ? batt_high_slow_ff : batt_high_fast_ff})),
            .lo     ($signed({3'b000, batt_low_ff})),
            .hi_cnt ((s == 0) ? slow_cnt_ff : ptm_pkg::CNT_W'(1)),
            .lo_cnt (release_cnt_ff),
            .ev     (det_ev[s])
         );
      end else if ((s - BATT_DETECTORS) / ADAPTER_DETECTORS < 2) begin : g_adapter
         localparam int K = (s - BATT_DETECTORS) / ADAPTER_DETECTORS;
         localparam int I = (s - BATT_DETECTORS) % ADAPTER_DETECTORS;
         ptm_detector u_det (
            .clock  (clock),
            .reset  (reset),
            .en     (adv && is_tick && !item_ff.ap_off && (adapter_ff == 1'(K))),
            .value  (ad_value),
            .hi     ($signed({5'b00000, ptm_pkg::AD_HI[K][I % 4]})),
            .lo     ($signed({5'b00000, ptm_pkg::AD_LO[K]})),
            .hi_cnt ((I == 0) ? slow_cnt_ff : ptm_pkg::CNT_W'(1)),
            .lo_cnt (release_cnt_ff),
            .ev     (det_ev[s])
         );
      end else begin : g_unused
         // only the 45W and 65W kinds can ever be selected
         assign det_ev[s] = '0;
      end
   end

   always_comb begin
      set_bits = '0;
      clr_bits = '0;
      for (int b = 0; b < REASON_W; b++) begin
         for (int s = 0; s < NUM_DET; s++) begin
            if (slot_bit(s) == b) begin
               set_bits[b] = set_bits[b] | det_ev[s].set;
               clr_bits[b] = clr_bits[b] | det_ev[s].clr;
            end
         end
      end
      reason_in = (reason_ff | set_bits) & ~clr_bits;
   end

   always_comb begin
      adapter_in = adapter_ff;
      if (adv) begin
         unique case (item_ff.func)
            ptm_pkg::FUNC_IDENTIFY:
               adapter_in = (item_ff.id_millivolts >= id_low_ff) &&
                            (item_ff.id_millivolts <= id_high_ff);
            ptm_pkg::FUNC_REMOVE: adapter_in = 1'b0;
            default:              adapter_in = adapter_ff;
         endcase
      end
   end

   assign reason_ext = {4'b0000, reason_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         reason_ff         <= '0;
         adapter_ff        <= 1'b0;
         batt_high_slow_ff <= 14'd5460;
         batt_high_fast_ff <= 14'd8400;
         batt_low_ff       <= 14'd3790;
         slow_cnt_ff       <= 6'd6;
         release_cnt_ff    <= 6'd32;
         id_low_ff         <= 12'd561;
         id_high_ff        <= 12'd717;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            item_valid_ff <= 1'b1;
         end else if (adv) begin
            item_valid_ff <= 1'b0;
         end
         if (adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (adv) begin
            reason_ff  <= reason_in;
            adapter_ff <= adapter_in;
         end
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               ptm_pkg::CSR_BATT_HIGH_SLOW:    batt_high_slow_ff <= csr_chan.data;
               ptm_pkg::CSR_BATT_HIGH_FAST:    batt_high_fast_ff <= csr_chan.data;
               ptm_pkg::CSR_BATT_LOW:          batt_low_ff       <= csr_chan.data;
               ptm_pkg::CSR_SLOW_ASSERT_COUNT: slow_cnt_ff    <= csr_chan.data[5:0];
               ptm_pkg::CSR_RELEASE_COUNT:     release_cnt_ff <= csr_chan.data[5:0];
               ptm_pkg::CSR_ID_65W_LOW:        id_low_ff  <= csr_chan.data[11:0];
               ptm_pkg::CSR_ID_65W_HIGH:       id_high_ff <= csr_chan.data[11:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.func            <= req_chan.func;
         item_ff.battery_current <= req_chan.battery_current;
         item_ff.adapter_current <= req_chan.adapter_current;
         item_ff.ap_off          <= req_chan.ap_off;
         item_ff.id_millivolts   <= req_chan.id_millivolts;
      end
      if (adv) begin
         rsp_throttle_ff <= |reason_in;
         rsp_reasons_ff  <= reason_ext[3:0];
         rsp_adapter_ff  <= adapter_in;
         rsp_limit_ff    <= ptm_pkg::AD_LIMIT[adapter_in];
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.throttle            = rsp_throttle_ff;
   assign rsp_chan.throttle_reasons    = rsp_reasons_ff;
   assign rsp_chan.adapter_class       = rsp_adapter_ff;
   assign rsp_chan.input_current_limit = rsp_limit_ff;

   `PTM_ASSERT_HOLDS(a_throttle_tracks_state, rsp_valid_ff,
      rsp_throttle_ff == (reason_ff != '0), "throttle disagrees with held reason bits")
   `PTM_ASSERT_HOLDS(a_limit_tracks_adapter, rsp_valid_ff,
      (rsp_adapter_ff == adapter_ff) && (rsp_limit_ff == ptm_pkg::AD_LIMIT[adapter_ff]),
      "limit disagrees with adapter type")
   `PTM_ASSERT_NEXT(a_stall_freezes_state, rsp_valid_ff && !rsp_chan.ready,
      $stable(reason_ff) && $stable(adapter_ff), "state moved while response stalled")
   `PTM_ASSERT_NEXT(a_event_keeps_reasons, adv && !is_tick,
      $stable(reason_ff), "adapter event changed reason bits")

endmodule

`default_nettype wire
